>>> rtl/core/utf8_text_field_validator_assert.svh
// assertion macros for the text field validator
`ifndef UTF8_TEXT_FIELD_VALIDATOR_ASSERT_SVH
`define UTF8_TEXT_FIELD_VALIDATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define UTFV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define UTFV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define UTFV_ASSERT(label, prop, msg)
`define UTFV_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> rtl/core/utfv_pkg.sv
package utfv_pkg;

  typedef enum logic [1:0] {
    MODE_TEXT        = 2'd0,
    MODE_HEX         = 2'd1,
    MODE_IDENT       = 2'd2,
    MODE_MODEL_IDENT = 2'd3
  } mode_e;

  typedef enum logic [0:0] {
    CFG_FIELD_MODE = 1'b0,
    CFG_MAX_LENGTH = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EMPTY     = 3'd1,
    ERR_TOO_LONG  = 3'd2,
    ERR_BAD_CHAR  = 3'd3,
    ERR_BAD_UTF8  = 3'd4,
    ERR_TRUNCATED = 3'd5
  } err_e;

  // bound on the first continuation byte after a lead
  typedef enum logic [2:0] {
    LIM_NONE  = 3'd0,
    LIM_GE_A0 = 3'd1,
    LIM_LT_A0 = 3'd2,
    LIM_GE_90 = 3'd3,
    LIM_LT_90 = 3'd4
  } lim_e;

  localparam logic [7:0]  LEAD2_LO   = 8'hc2;
  localparam logic [7:0]  LEAD2_HI   = 8'hdf;
  localparam logic [7:0]  LEAD3_LO   = 8'he0;
  localparam logic [7:0]  LEAD3_HI   = 8'hef;
  localparam logic [7:0]  LEAD3_SURR = 8'hed;
  localparam logic [7:0]  LEAD4_LO   = 8'hf0;
  localparam logic [7:0]  LEAD4_HI   = 8'hf4;
  localparam logic [7:0]  CONT_MASK  = 8'hc0;
  localparam logic [7:0]  CONT_TAG   = 8'h80;
  localparam logic [7:0]  BOUND_A0   = 8'ha0;
  localparam logic [7:0]  BOUND_90   = 8'h90;
  localparam logic [7:0]  DEL_CHAR   = 8'h7f;
  localparam logic [7:0]  CTRL_LIMIT = 8'h20;

  localparam logic [15:0] MAX_LEN_RST = 16'd511;
  localparam logic [16:0] COUNT_SAT   = 17'h10000;

  typedef struct packed {
    logic [1:0] pend;
    lim_e       lim;
  } cont_t;

  typedef struct packed {
    cont_t cont;
    err_e  err;
  } chk_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       carries_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic        field_ok;
    logic [2:0]  error_kind;
    logic [16:0] byte_count;
    logic        last_of_run;
  } out_item_t;

endpackage

>>> rtl/core/utfv_if.sv
interface utfv_in_if;
  logic               valid;
  logic               ready;
  utfv_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface utfv_out_if;
  logic                valid;
  logic                ready;
  utfv_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/utfv_byte_check.sv
module utfv_byte_check (
  input  utfv_pkg::mode_e mode_i,
  input  utfv_pkg::cont_t cont_i,
  input  logic [7:0]      byte_i,
  output utfv_pkg::chk_t  chk_o
);

  logic alnum;
  logic ident_ok;
  logic model_ok;
  logic hex_digit;
  logic is_hex;
  logic lim_ok;
  logic cont_good;

  assign alnum = (byte_i >= "A" && byte_i <= "Z") || (byte_i >= "a" && byte_i <= "z") ||
                 (byte_i >= "0" && byte_i <= "9");
  assign ident_ok = alnum || byte_i == "." || byte_i == "_" || byte_i == "-";
  assign model_ok = byte_i == ":" || byte_i == "/" || byte_i == "+";
  assign hex_digit = (byte_i >= "0" && byte_i <= "9") || (byte_i >= "a" && byte_i <= "f");
  assign is_hex = (mode_i == utfv_pkg::MODE_HEX);

  always_comb begin
    unique case (cont_i.lim)
      utfv_pkg::LIM_GE_A0: lim_ok = (byte_i >= utfv_pkg::BOUND_A0);
      utfv_pkg::LIM_LT_A0: lim_ok = (byte_i < utfv_pkg::BOUND_A0);
      utfv_pkg::LIM_GE_90: lim_ok = (byte_i >= utfv_pkg::BOUND_90);
      utfv_pkg::LIM_LT_90: lim_ok = (byte_i < utfv_pkg::BOUND_90);
      default:             lim_ok = 1'b1;
    endcase
  end

  assign cont_good = ((byte_i & utfv_pkg::CONT_MASK) == utfv_pkg::CONT_TAG) && lim_ok;

  always_comb begin
    chk_o.cont = cont_i;
    chk_o.err  = utfv_pkg::ERR_NONE;
    priority if (mode_i == utfv_pkg::MODE_IDENT || mode_i == utfv_pkg::MODE_MODEL_IDENT) begin
      chk_o.cont.pend = 2'd0;
      chk_o.cont.lim  = utfv_pkg::LIM_NONE;
      if (!(ident_ok || (mode_i == utfv_pkg::MODE_MODEL_IDENT && model_ok))) begin
        chk_o.err = utfv_pkg::ERR_BAD_CHAR;
      end
    end else if (cont_i.pend != 2'd0) begin
      chk_o.cont.lim = utfv_pkg::LIM_NONE;
      if (!cont_good) begin
        chk_o.cont.pend = 2'd0;
        chk_o.err       = utfv_pkg::ERR_BAD_UTF8;
      end else begin
        chk_o.cont.pend = cont_i.pend - 2'd1;
        chk_o.err       = is_hex ? utfv_pkg::ERR_BAD_CHAR : utfv_pkg::ERR_NONE;
      end
    end else if (byte_i < utfv_pkg::CONT_TAG) begin
      if (byte_i < utfv_pkg::CTRL_LIMIT || byte_i == utfv_pkg::DEL_CHAR) begin
        chk_o.err = utfv_pkg::ERR_BAD_CHAR;
      end else if (is_hex && !hex_digit) begin
        chk_o.err = utfv_pkg::ERR_BAD_CHAR;
      end
    end else if (byte_i >= utfv_pkg::LEAD2_LO && byte_i <= utfv_pkg::LEAD2_HI) begin
      chk_o.cont.pend = 2'd1;
      chk_o.cont.lim  = utfv_pkg::LIM_NONE;
      chk_o.err       = is_hex ? utfv_pkg::ERR_BAD_CHAR : utfv_pkg::ERR_NONE;
    end else if (byte_i >= utfv_pkg::LEAD3_LO && byte_i <= utfv_pkg::LEAD3_HI) begin
      chk_o.cont.pend = 2'd2;
      chk_o.cont.lim  = (byte_i == utfv_pkg::LEAD3_LO)   ? utfv_pkg::LIM_GE_A0 :
                        (byte_i == utfv_pkg::LEAD3_SURR) ? utfv_pkg::LIM_LT_A0 :
                                                           utfv_pkg::LIM_NONE;
      chk_o.err       = is_hex ? utfv_pkg::ERR_BAD_CHAR : utfv_pkg::ERR_NONE;
    end else if (byte_i >= utfv_pkg::LEAD4_LO && byte_i <= utfv_pkg::LEAD4_HI) begin
      chk_o.cont.pend = 2'd3;
      chk_o.cont.lim  = (byte_i == utfv_pkg::LEAD4_LO) ? utfv_pkg::LIM_GE_90 :
                        (byte_i == utfv_pkg::LEAD4_HI) ? utfv_pkg::LIM_LT_90 :
                                                         utfv_pkg::LIM_NONE;
      chk_o.err       = is_hex ? utfv_pkg::ERR_BAD_CHAR : utfv_pkg::ERR_NONE;
    end else begin
      chk_o.err = utfv_pkg::ERR_BAD_UTF8;
    end
  end

endmodule

>>> rtl/core/utf8_text_field_validator.sv
// text field validator
// in_if_i carries one byte of a string per transaction, with carries_byte
// marking a real byte and end_of_string marking the last transaction of the
// string. an empty string is sent as one transaction with carries_byte low
// and end_of_string high.
// out_if_o carries one verdict per string: field_ok, the error kind (empty,
// too long, first byte error, truncated, in that priority), the saturated byte count and last_of_run.
// the verdict is registered and valid in the cycle after the end_of_string transaction is taken.
// one transaction per cycle is taken unless stalled; the running state and the
// verdict register are updated in the same cycle by one pass of byte checking.
// the config port (cfg_we_i, cfg_index_i, cfg_data_i) sets field_mode and
// max_length; writes are meant for idle periods between strings.
// reset clears the running state, drops any held verdict and loads
// field_mode = canonical text and max_length = 511.
// when the receiver stalls, the held verdict stays on out_if_o and in_if_i
// stops taking transactions until the verdict is taken; the verdict
// register is reloaded in the cycle it is taken, so there is no bubble.
`include "utf8_text_field_validator_assert.svh"

module utf8_text_field_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  utfv_in_if.sink     in_if_i,
  utfv_out_if.source  out_if_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  utfv_pkg::mode_e     mode_q;
  logic [15:0]         max_len_q;
  utfv_pkg::cont_t     cont_q, cont_d;
  logic [16:0]         seen_q, seen_d;
  utfv_pkg::err_e      first_err_q, first_err_d;
  logic                out_valid_q;
  utfv_pkg::out_item_t out_q, out_d;

  utfv_pkg::chk_t      chk;
  logic                in_ready;
  logic                accept;
  utfv_pkg::err_e      kind;

  utfv_byte_check u_byte_check (
    .mode_i (mode_q),
    .cont_i (cont_q),
    .byte_i (in_if_i.data.text_byte),
    .chk_o  (chk)
  );

  assign in_ready       = !out_valid_q || out_if_o.ready;
  assign in_if_i.ready  = in_ready;
  assign accept         = in_if_i.valid && in_ready;
  assign out_if_o.valid = out_valid_q;
  assign out_if_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= utfv_pkg::MODE_TEXT;
      max_len_q <= utfv_pkg::MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (utfv_pkg::cfg_e'(cfg_index_i))
        utfv_pkg::CFG_FIELD_MODE: mode_q    <= utfv_pkg::mode_e'(cfg_data_i[1:0]);
        utfv_pkg::CFG_MAX_LENGTH: max_len_q <= cfg_data_i;
      endcase
    end
  end

  // state after the current byte
  always_comb begin
    cont_d      = cont_q;
    seen_d      = seen_q;
    first_err_d = first_err_q;
    if (in_if_i.data.carries_byte) begin
      cont_d = chk.cont;
      if (seen_q != utfv_pkg::COUNT_SAT) begin
        seen_d = seen_q + 17'd1;
      end
      if (first_err_q == utfv_pkg::ERR_NONE) begin
        first_err_d = chk.err;
      end
    end
  end

  always_comb begin
    priority if (seen_d == 17'd0) begin
      kind = utfv_pkg::ERR_EMPTY;
    end else if (seen_d > {1'b0, max_len_q}) begin
      kind = utfv_pkg::ERR_TOO_LONG;
    end else if (first_err_d != utfv_pkg::ERR_NONE) begin
      kind = first_err_d;
    end else if (cont_d.pend != 2'd0) begin
      kind = utfv_pkg::ERR_TRUNCATED;
    end else begin
      kind = utfv_pkg::ERR_NONE;
    end
    out_d.field_ok    = (kind == utfv_pkg::ERR_NONE);
    out_d.error_kind  = kind;
    out_d.byte_count  = seen_d;
    out_d.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cont_q      <= '{pend: 2'd0, lim: utfv_pkg::LIM_NONE};
      seen_q      <= 17'd0;
      first_err_q <= utfv_pkg::ERR_NONE;
    end else if (accept) begin
      if (in_if_i.data.end_of_string) begin
        cont_q      <= '{pend: 2'd0, lim: utfv_pkg::LIM_NONE};
        seen_q      <= 17'd0;
        first_err_q <= utfv_pkg::ERR_NONE;
      end else begin
        cont_q      <= cont_d;
        seen_q      <= seen_d;
        first_err_q <= first_err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && in_if_i.data.end_of_string) begin
      out_valid_q <= 1'b1;
    end else if (out_if_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_if_i.data.end_of_string) begin
      out_q <= out_d;
    end
  end

  `UTFV_ASSERT(a_stall_blocks_input, out_valid_q && !out_if_o.ready |-> !in_if_i.ready,
               "input taken while verdict is stalled")
  `UTFV_ASSERT(a_end_gives_verdict, accept && in_if_i.data.end_of_string |=> out_valid_q && seen_q == 17'd0 && cont_q.pend == 2'd0,
               "end of string did not yield a verdict and clear the state")
  `UTFV_ASSERT(a_ok_matches_kind, out_valid_q |-> out_q.field_ok == (out_q.error_kind == utfv_pkg::ERR_NONE),
               "field_ok disagrees with error_kind")
  `UTFV_ASSERT_ALWAYS(a_lim_needs_pend, cont_q.pend == 2'd0 |-> cont_q.lim == utfv_pkg::LIM_NONE,
                      "continuation bound set with nothing pending")

endmodule

>>> dv/utf8_text_field_validator_test.sv
`timescale 1ns / 1ps

module utf8_text_field_validator_test;

  localparam int ITEM_TARGET     = 1050;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int HOLD_AFTER      = 60;

  typedef enum {RX_OPEN, RX_SPOTTY, RX_PERIODIC, RX_SPARSE} rx_style_e;
  typedef enum {FLAW_SWAP, FLAW_CLIP, FLAW_EXTRA_CONT, FLAW_STRAY_LEAD} flaw_e;

  typedef struct packed {
    utfv_pkg::mode_e     mode;
    logic [15:0]         max_len;
    logic [7:0]          text_byte;
    logic                carries;
    logic                eos;
    logic                known;
    utfv_pkg::out_item_t want;
  } probe_row_t;

  localparam probe_row_t PROBES [25] = '{
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'h00, 1'b0, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_EMPTY, 17'd0, 1'b1}},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'h00, 1'b1, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_BAD_CHAR, 17'd1, 1'b1}},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'hff, 1'b0, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'hf0, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'h9f, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'h98, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'h80, 1'b1, 1'b1, 1'b1,
      {1'b1, utfv_pkg::ERR_NONE, 17'd4, 1'b1}},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'hed, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'ha0, 1'b1, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_BAD_UTF8, 17'd2, 1'b1}},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'hc2, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'h7f, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'h00, 1'b0, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_BAD_UTF8, 17'd2, 1'b1}},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'he2, 1'b1, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_TRUNCATED, 17'd1, 1'b1}},
    '{utfv_pkg::MODE_HEX, 16'd511, 8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_HEX, 16'd511, 8'hc3, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_HEX, 16'd511, 8'ha9, 1'b1, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_BAD_CHAR, 17'd3, 1'b1}},
    '{utfv_pkg::MODE_HEX, 16'd511, 8'hfe, 1'b1, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_BAD_UTF8, 17'd1, 1'b1}},
    '{utfv_pkg::MODE_TEXT, 16'd511, 8'he0, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_IDENT, 16'd511, 8'h5a, 1'b1, 1'b1, 1'b0, '0},
    '{utfv_pkg::MODE_MODEL_IDENT, 16'd511, 8'h2f, 1'b1, 1'b1, 1'b1,
      {1'b1, utfv_pkg::ERR_NONE, 17'd1, 1'b1}},
    '{utfv_pkg::MODE_MODEL_IDENT, 16'd0, 8'h41, 1'b1, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_TOO_LONG, 17'd1, 1'b1}},
    '{utfv_pkg::MODE_MODEL_IDENT, 16'd1, 8'h3a, 1'b1, 1'b0, 1'b0, '0},
    '{utfv_pkg::MODE_MODEL_IDENT, 16'd1, 8'h2b, 1'b1, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_TOO_LONG, 17'd2, 1'b1}},
    '{utfv_pkg::MODE_IDENT, 16'hffff, 8'h2b, 1'b1, 1'b1, 1'b1,
      {1'b0, utfv_pkg::ERR_BAD_CHAR, 17'd1, 1'b1}},
    '{utfv_pkg::MODE_TEXT, 16'hffff, 8'h7e, 1'b1, 1'b1, 1'b1,
      {1'b1, utfv_pkg::ERR_NONE, 17'd1, 1'b1}}
  };

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  utfv_pkg::cfg_e  cfg_index;
  logic [15:0]     cfg_data;

  utfv_in_if  in_ch ();
  utfv_out_if out_ch ();

  utf8_text_field_validator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if_i     (in_ch),
    .out_if_o    (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copy
  utfv_pkg::mode_e mode_now    = utfv_pkg::MODE_TEXT;
  logic [15:0]     max_len_now = utfv_pkg::MAX_LEN_RST;
  logic [1:0]      pend_cont   = '0;
  utfv_pkg::lim_e  cont_bound  = utfv_pkg::LIM_NONE;
  logic [16:0]     seen_count  = '0;
  utfv_pkg::err_e  first_fault = utfv_pkg::ERR_NONE;

  utfv_pkg::out_item_t pending_verdicts[$];
  logic [7:0]          word_q[$];
  int                  items_sent     = 0;
  int                  verdicts_taken = 0;
  int                  fail_count     = 0;
  int                  burst_left     = 0;
  int                  quiet_cycles   = 0;

  string hex_digits  = "0123456789abcdef";
  string ident_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._-";
  string model_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._-:/+";

  function automatic utfv_pkg::err_e classify_byte(logic [7:0] c);
    bit hex_only;
    bit good;
    hex_only = (mode_now == utfv_pkg::MODE_HEX);
    if (mode_now == utfv_pkg::MODE_IDENT || mode_now == utfv_pkg::MODE_MODEL_IDENT) begin
      pend_cont  = '0;
      cont_bound = utfv_pkg::LIM_NONE;
      if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
          c == "." || c == "_" || c == "-")
        return utfv_pkg::ERR_NONE;
      if (mode_now == utfv_pkg::MODE_MODEL_IDENT && (c == ":" || c == "/" || c == "+"))
        return utfv_pkg::ERR_NONE;
      return utfv_pkg::ERR_BAD_CHAR;
    end
    if (pend_cont != 0) begin
      case (cont_bound)
        utfv_pkg::LIM_GE_A0: good = (c >= utfv_pkg::BOUND_A0);
        utfv_pkg::LIM_LT_A0: good = (c < utfv_pkg::BOUND_A0);
        utfv_pkg::LIM_GE_90: good = (c >= utfv_pkg::BOUND_90);
        utfv_pkg::LIM_LT_90: good = (c < utfv_pkg::BOUND_90);
        default:             good = 1'b1;
      endcase
      good = good && ((c & utfv_pkg::CONT_MASK) == utfv_pkg::CONT_TAG);
      cont_bound = utfv_pkg::LIM_NONE;
      if (!good) begin
        pend_cont = '0;
        return utfv_pkg::ERR_BAD_UTF8;
      end
      pend_cont--;
      return hex_only ? utfv_pkg::ERR_BAD_CHAR : utfv_pkg::ERR_NONE;
    end
    if (c < utfv_pkg::CONT_TAG) begin
      if (c < utfv_pkg::CTRL_LIMIT || c == utfv_pkg::DEL_CHAR)
        return utfv_pkg::ERR_BAD_CHAR;
      if (hex_only && !((c >= "0" && c <= "9") || (c >= "a" && c <= "f")))
        return utfv_pkg::ERR_BAD_CHAR;
      return utfv_pkg::ERR_NONE;
    end
    if (c >= utfv_pkg::LEAD2_LO && c <= utfv_pkg::LEAD2_HI) begin
      pend_cont  = 2'd1;
      cont_bound = utfv_pkg::LIM_NONE;
    end else if (c >= utfv_pkg::LEAD3_LO && c <= utfv_pkg::LEAD3_HI) begin
      pend_cont = 2'd2;
      if (c == utfv_pkg::LEAD3_LO) cont_bound = utfv_pkg::LIM_GE_A0;
      else if (c == utfv_pkg::LEAD3_SURR) cont_bound = utfv_pkg::LIM_LT_A0;
      else cont_bound = utfv_pkg::LIM_NONE;
    end else if (c >= utfv_pkg::LEAD4_LO && c <= utfv_pkg::LEAD4_HI) begin
      pend_cont = 2'd3;
      if (c == utfv_pkg::LEAD4_LO) cont_bound = utfv_pkg::LIM_GE_90;
      else if (c == utfv_pkg::LEAD4_HI) cont_bound = utfv_pkg::LIM_LT_90;
      else cont_bound = utfv_pkg::LIM_NONE;
    end else begin
      return utfv_pkg::ERR_BAD_UTF8;
    end
    return hex_only ? utfv_pkg::ERR_BAD_CHAR : utfv_pkg::ERR_NONE;
  endfunction

  // advances the running string state; returns 1 when the item ends a string
  function automatic bit fold_item(utfv_pkg::in_item_t it,
                                   output utfv_pkg::out_item_t verdict);
    utfv_pkg::err_e fault;
    utfv_pkg::err_e kind;
    verdict = '0;
    if (it.carries_byte) begin
      if (seen_count < utfv_pkg::COUNT_SAT) seen_count++;
      fault = classify_byte(it.text_byte);
      if (first_fault == utfv_pkg::ERR_NONE) first_fault = fault;
    end
    if (!it.end_of_string) return 1'b0;
    if (seen_count == 0) kind = utfv_pkg::ERR_EMPTY;
    else if (seen_count > {1'b0, max_len_now}) kind = utfv_pkg::ERR_TOO_LONG;
    else if (first_fault != utfv_pkg::ERR_NONE) kind = first_fault;
    else if (pend_cont != 0) kind = utfv_pkg::ERR_TRUNCATED;
    else kind = utfv_pkg::ERR_NONE;
    verdict.field_ok    = (kind == utfv_pkg::ERR_NONE);
    verdict.error_kind  = kind;
    verdict.byte_count  = seen_count;
    verdict.last_of_run = 1'b1;
    pend_cont   = '0;
    cont_bound  = utfv_pkg::LIM_NONE;
    seen_count  = '0;
    first_fault = utfv_pkg::ERR_NONE;
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [7:0] pick_range(int lo, int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] pick_set(string s);
    return s[$urandom_range(s.len() - 1, 0)];
  endfunction

  function automatic void push_text_char();
    logic [7:0] lead;
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: word_q.push_back(pick_range(8'h20, 8'h7e));
      5, 6: begin
        word_q.push_back(pick_range(utfv_pkg::LEAD2_LO, utfv_pkg::LEAD2_HI));
        word_q.push_back(pick_range(8'h80, 8'hbf));
      end
      7, 8: begin
        lead = pick_range(utfv_pkg::LEAD3_LO, utfv_pkg::LEAD3_HI);
        word_q.push_back(lead);
        if (lead == utfv_pkg::LEAD3_LO)
          word_q.push_back(pick_range(utfv_pkg::BOUND_A0, 8'hbf));
        else if (lead == utfv_pkg::LEAD3_SURR)
          word_q.push_back(pick_range(utfv_pkg::CONT_TAG, 8'h9f));
        else word_q.push_back(pick_range(8'h80, 8'hbf));
        word_q.push_back(pick_range(8'h80, 8'hbf));
      end
      default: begin
        lead = pick_range(utfv_pkg::LEAD4_LO, utfv_pkg::LEAD4_HI);
        word_q.push_back(lead);
        if (lead == utfv_pkg::LEAD4_LO)
          word_q.push_back(pick_range(utfv_pkg::BOUND_90, 8'hbf));
        else if (lead == utfv_pkg::LEAD4_HI)
          word_q.push_back(pick_range(utfv_pkg::CONT_TAG, 8'h8f));
        else word_q.push_back(pick_range(8'h80, 8'hbf));
        word_q.push_back(pick_range(8'h80, 8'hbf));
        word_q.push_back(pick_range(8'h80, 8'hbf));
      end
    endcase
  endfunction

  function automatic void build_word(utfv_pkg::mode_e m, int n_chars);
    word_q.delete();
    repeat (n_chars) begin
      case (m)
        utfv_pkg::MODE_TEXT:  push_text_char();
        utfv_pkg::MODE_HEX:   word_q.push_back(pick_set(hex_digits));
        utfv_pkg::MODE_IDENT: word_q.push_back(pick_set(ident_chars));
        default:              word_q.push_back(pick_set(model_chars));
      endcase
    end
  endfunction

  function automatic void spoil_word();
    int pos;
    flaw_e flaw;
    if (word_q.size() == 0) return;
    pos  = $urandom_range(word_q.size() - 1, 0);
    flaw = flaw_e'($urandom_range(3, 0));
    case (flaw)
      FLAW_SWAP:       word_q[pos] = 8'($urandom);
      FLAW_CLIP:       if (word_q.size() > 1) void'(word_q.pop_back());
      FLAW_EXTRA_CONT: word_q.insert(pos, pick_range(8'h80, 8'hbf));
      default:         word_q[pos] = pick_range(8'hc0, 8'hff);
    endcase
  endfunction

  task automatic offer(input utfv_pkg::in_item_t it, input bit typed = 1'b0,
                       input utfv_pkg::out_item_t typed_v = '0);
    utfv_pkg::out_item_t v;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(32, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (it.carries_byte || it.end_of_string) items_sent++;
    if (fold_item(it, v)) pending_verdicts.push_back(typed ? typed_v : v);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input utfv_pkg::cfg_e idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_config(input utfv_pkg::mode_e m, input logic [15:0] ml);
    if (m == mode_now && ml == max_len_now) return;
    settle();
    if (m != mode_now) begin
      // upper data bits are don't-care for the mode register
      write_reg(utfv_pkg::CFG_FIELD_MODE, {14'($urandom), m});
      mode_now = m;
    end
    if (ml != max_len_now) begin
      write_reg(utfv_pkg::CFG_MAX_LENGTH, ml);
      max_len_now = ml;
    end
  endtask

  task automatic send_word(input bit use_term);
    int last;
    last = word_q.size() - 1;
    foreach (word_q[i]) begin
      if ($urandom_range(9, 0) == 0) offer({8'($urandom), 1'b0, 1'b0});
      offer({word_q[i], 1'b1, (i == last) && !use_term});
    end
    if (use_term || word_q.size() == 0) offer({8'($urandom), 1'b0, 1'b1});
  endtask

  task automatic run_random_phase();
    utfv_pkg::mode_e m;
    logic [15:0] ml;
    int n_strings;
    int n_chars;
    int shape;
    m = utfv_pkg::mode_e'($urandom_range(3, 0));
    case ($urandom_range(9, 0))
      0:       ml = 16'd0;
      1:       ml = 16'd1;
      2, 3:    ml = 16'($urandom_range(24, 2));
      4:       ml = 16'hffff;
      default: ml = utfv_pkg::MAX_LEN_RST;
    endcase
    apply_config(m, ml);
    n_strings = $urandom_range(30, 6);
    repeat (n_strings) begin
      if (ml <= 24) n_chars = $urandom_range(int'(ml) + 2, 0);
      else n_chars = ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(20, 1);
      build_word(m, n_chars);
      shape = $urandom_range(9, 0);
      if (shape == 0) begin
        foreach (word_q[i]) word_q[i] = 8'($urandom);
      end else if (shape <= 2) begin
        spoil_word();
      end
      send_word($urandom_range(4, 0) == 0);
    end
  endtask

  // verdict checking
  always @(posedge clk) begin
    utfv_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      verdicts_taken++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: verdict expected none actual %p", $time, out_ch.data);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("field_ok", want.field_ok, out_ch.data.field_ok);
        check_field("error_kind", want.error_kind, out_ch.data.error_kind);
        check_field("byte_count", want.byte_count, out_ch.data.byte_count);
        check_field("last_of_run", want.last_of_run, out_ch.data.last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver stall patterns, plus one long hold-off to back up the input
  initial begin
    rx_style_e style;
    int span;
    int tick;
    bit held;
    out_ch.ready = 1'b0;
    held = 1'b0;
    tick = 0;
    forever begin
      style = rx_style_e'($urandom_range(3, 0));
      span  = $urandom_range(200, 20);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (!held && verdicts_taken >= HOLD_AFTER) begin
          held = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(negedge clk);
        end
        case (style)
          RX_OPEN:     out_ch.ready <= 1'b1;
          RX_SPOTTY:   out_ch.ready <= ($urandom_range(9, 0) > 2);
          RX_PERIODIC: out_ch.ready <= (tick % 3 != 0);
          default:     out_ch.ready <= ($urandom_range(9, 0) == 0);
        endcase
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_index   = utfv_pkg::CFG_FIELD_MODE;
    cfg_data    = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (PROBES[i]) begin
      apply_config(PROBES[i].mode, PROBES[i].max_len);
      offer({PROBES[i].text_byte, PROBES[i].carries, PROBES[i].eos},
            PROBES[i].known, PROBES[i].want);
    end

    while (items_sent < ITEM_TARGET) run_random_phase();

    settle();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/utfv_pkg.sv
rtl/core/utfv_if.sv
rtl/core/utfv_byte_check.sv
rtl/core/utf8_text_field_validator.sv
dv/utf8_text_field_validator_test.sv
